// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [3:0] {
    OP_NORM  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_CMP   = 4'd5,
    OP_FLOOR = 4'd6,
    OP_CEIL  = 4'd7,
    OP_ROUND = 4'd8,
    OP_ABS   = 4'd9,
    OP_NEG   = 4'd10,
    OP_INV   = 4'd11
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [3:0] MUL_LAST = 4'd11;
  localparam logic [6:0] DIV_LAST = 7'd127;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_MUL,
    S_TAIL,
    S_COMB,
    S_GINIT,
    S_GCD,
    S_DINIT,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       load;
    logic       early;
    logic       mul;
    logic [3:0] mul_idx;
    logic       comb;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic early_hit;
    logic is_cmp;
    logic is_int;
    logic gcd_done;
  } stat_t;

endpackage

// File: rtl/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: checks, multiply passes, gcd loop, division loop, result strobe.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output rau_pkg::cmd_t  cmd,
  input  rau_pkg::stat_t stat
);

  rau_pkg::state_t state, state_next;
  logic [3:0] mcnt, mcnt_next;
  logic [6:0] dcnt, dcnt_next;
  logic       emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
      mcnt  <= '0;
      dcnt  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      mcnt  <= mcnt_next;
      dcnt  <= dcnt_next;
      done  <= emit;
    end
  end

  assign busy = (state != rau_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    mcnt_next  = mcnt;
    dcnt_next  = dcnt;
    emit       = 1'b0;
    cmd        = '0;
    cmd.mul_idx = mcnt;
    unique case (state)
      rau_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = rau_pkg::S_PRE;
        end
      end
      rau_pkg::S_PRE: begin
        if (stat.early_hit) begin
          cmd.early  = 1'b1;
          emit       = 1'b1;
          state_next = rau_pkg::S_IDLE;
        end else begin
          mcnt_next  = '0;
          state_next = rau_pkg::S_MUL;
        end
      end
      rau_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        mcnt_next = mcnt + 4'd1;
        if (mcnt == rau_pkg::MUL_LAST) state_next = rau_pkg::S_TAIL;
      end
      rau_pkg::S_TAIL: state_next = rau_pkg::S_COMB;
      rau_pkg::S_COMB: begin
        cmd.comb = 1'b1;
        priority if (stat.is_cmp) state_next = rau_pkg::S_FIN;
        else if (stat.is_int)     state_next = rau_pkg::S_DINIT;
        else                      state_next = rau_pkg::S_GINIT;
      end
      rau_pkg::S_GINIT: begin
        cmd.gcd_init = 1'b1;
        state_next   = rau_pkg::S_GCD;
      end
      rau_pkg::S_GCD: begin
        if (stat.gcd_done) state_next = rau_pkg::S_DINIT;
        else cmd.gcd_step = 1'b1;
      end
      rau_pkg::S_DINIT: begin
        cmd.div_init = 1'b1;
        dcnt_next    = '0;
        state_next   = rau_pkg::S_DIV;
      end
      rau_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt + 7'd1;
        if (dcnt == rau_pkg::DIV_LAST) state_next = rau_pkg::S_FIN;
      end
      rau_pkg::S_FIN: begin
        cmd.fin    = 1'b1;
        emit       = 1'b1;
        state_next = rau_pkg::S_IDLE;
      end
      default: state_next = rau_pkg::S_IDLE;
    endcase
  end

endmodule

// File: rtl/rau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, 32x32 multiplier, binary gcd, dual restoring divider.
// ----------------------------------------------------------------------------
module rau_datapath #(
  parameter int WORD_BITS = 64
) (
  input  logic                clk,
  input  rau_pkg::cmd_t       cmd,
  output rau_pkg::stat_t      stat,
  input  logic [3:0]          op,
  input  logic signed [63:0]  a_num,
  input  logic signed [63:0]  a_den,
  input  logic signed [63:0]  b_num,
  input  logic [62:0]         b_den,
  output logic signed [63:0]  res_num,
  output logic [62:0]         res_den,
  output logic signed [63:0]  res_int,
  output logic [1:0]          order,
  output logic [1:0]          status
);

  localparam logic [127:0] LIM = 128'd1 << (WORD_BITS - 1);

  logic [3:0]   op_q;
  logic         sa, sb, sgn;
  logic [63:0]  am, adm, bm, bd;
  logic [63:0]  pp;
  logic [3:0]   pk;
  logic         pv;
  logic [127:0] acc, p0, p1, p2;
  logic [127:0] nr, dr;
  logic [127:0] ga, gb;
  logic [6:0]   gsh;
  logic [127:0] dv, r1, q1, r2, q2;
  logic [1:0]   ord_q;

  function automatic logic fits(input logic neg, input logic [127:0] mag);
    logic [127:0] lim;
    lim = LIM - {127'd0, ~neg};
    return mag <= lim;
  endfunction

  // ---- early checks
  logic       bin_op, early_hit;
  logic [1:0] early_st;
  always_comb begin
    bin_op    = (op_q >= rau_pkg::OP_ADD) && (op_q <= rau_pkg::OP_CMP);
    early_hit = 1'b1;
    early_st  = rau_pkg::ST_DIVZ;
    priority if (op_q > rau_pkg::OP_INV)       early_st = rau_pkg::ST_OK;
    else if (adm == '0 || (bin_op && bd == '0)) early_st = rau_pkg::ST_ZDEN;
    else if (op_q == rau_pkg::OP_DIV && bm == '0) early_st = rau_pkg::ST_DIVZ;
    else if (op_q == rau_pkg::OP_INV && am == '0) early_st = rau_pkg::ST_DIVZ;
    else early_hit = 1'b0;
  end

  // ---- multiplier operand select
  logic [63:0]  mx, my;
  logic [31:0]  xs, ys;
  logic [127:0] sh_pp, acc_next;
  always_comb begin
    unique case (cmd.mul_idx[3:2])
      2'd0:    begin mx = am;  my = (op_q == rau_pkg::OP_MUL) ? bm : bd; end
      2'd1:    begin mx = bm;  my = adm; end
      default: begin mx = adm; my = (op_q == rau_pkg::OP_DIV) ? bm : bd; end
    endcase
    xs = cmd.mul_idx[0] ? mx[63:32] : mx[31:0];
    ys = cmd.mul_idx[1] ? my[63:32] : my[31:0];
    unique case (pk[1:0])
      2'd0:    sh_pp = {64'd0, pp};
      2'd3:    sh_pp = {pp, 64'd0};
      default: sh_pp = {32'd0, pp, 32'd0};
    endcase
    acc_next = ((pk[1:0] == 2'd0) ? 128'd0 : acc) + sh_pp;
  end

  // ---- combine
  logic         sbx, cs, neq_sgn;
  logic [127:0] cm;
  always_comb begin
    sbx = (op_q == rau_pkg::OP_ADD) ? sb : ~sb;
    priority if (sa == sbx) begin cm = p0 + p1; cs = sa;  end
    else if (p0 >= p1)      begin cm = p0 - p1; cs = sa;  end
    else                    begin cm = p1 - p0; cs = sbx; end
    if (cm == '0) cs = 1'b0;
    neq_sgn = sa ^ sb;
  end

  // ---- divider step
  logic [128:0] t1, t2;
  logic         k1, k2;
  always_comb begin
    t1 = {r1, q1[127]};
    t2 = {r2, q2[127]};
    k1 = t1 >= {1'b0, dv};
    k2 = t2 >= {1'b0, dv};
  end

  // ---- finish
  logic [127:0] qq;
  logic [63:0]  rem64, dif64;
  logic         up, fneg, ineg;
  always_comb begin
    rem64 = r1[63:0];
    dif64 = dr[63:0] - rem64;
    unique case (op_q)
      rau_pkg::OP_FLOOR: up = sgn && rem64 != '0;
      rau_pkg::OP_CEIL:  up = !sgn && rem64 != '0;
      default:           up = rem64 >= dif64;
    endcase
    qq   = q1 + {127'd0, up};
    ineg = sgn && qq != '0;
    fneg = sgn && q1 != '0;
  end

  always_ff @(posedge clk) begin
    pk <= cmd.mul_idx;
    pv <= cmd.mul;
    if (cmd.mul) pp <= xs * ys;
    if (pv) begin
      acc <= acc_next;
      if (pk[1:0] == 2'd3) begin
        unique case (pk[3:2])
          2'd0:    p0 <= acc_next;
          2'd1:    p1 <= acc_next;
          default: p2 <= acc_next;
        endcase
      end
    end

    if (cmd.load) begin
      op_q <= op;
      sa   <= a_num[63] ^ a_den[63];
      sb   <= b_num[63];
      am   <= a_num[63] ? 64'(-a_num) : a_num;
      adm  <= a_den[63] ? 64'(-a_den) : a_den;
      bm   <= b_num[63] ? 64'(-b_num) : b_num;
      bd   <= {1'b0, b_den};
    end

    if (cmd.comb) begin
      unique case (op_q)
        rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_CMP: begin
          nr <= cm; dr <= p2; sgn <= cs;
          if (cm == '0) ord_q <= rau_pkg::ORD_EQ;
          else ord_q <= cs ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
        end
        rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
          nr <= p0; dr <= p2; sgn <= neq_sgn;
        end
        rau_pkg::OP_INV: begin
          nr <= {64'd0, adm}; dr <= {64'd0, am}; sgn <= sa;
        end
        rau_pkg::OP_ABS: begin
          nr <= {64'd0, am}; dr <= {64'd0, adm}; sgn <= 1'b0;
        end
        rau_pkg::OP_NEG: begin
          nr <= {64'd0, am}; dr <= {64'd0, adm}; sgn <= ~sa;
        end
        default: begin
          nr <= {64'd0, am}; dr <= {64'd0, adm}; sgn <= sa;
        end
      endcase
    end

    if (cmd.gcd_init) begin
      gsh <= '0;
      if (nr == '0) begin
        ga <= dr; gb <= '0;
      end else begin
        ga <= nr; gb <= dr;
      end
    end else if (cmd.gcd_step) begin
      priority if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1; gb <= gb >> 1; gsh <= gsh + 7'd1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga > gb) begin
        ga <= gb; gb <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end

    if (cmd.div_init) begin
      r1 <= '0; r2 <= '0; q1 <= nr; q2 <= dr;
      dv <= stat.is_int ? dr : (ga << gsh);
    end else if (cmd.div_step) begin
      r1 <= k1 ? 128'(t1 - {1'b0, dv}) : t1[127:0];
      r2 <= k2 ? 128'(t2 - {1'b0, dv}) : t2[127:0];
      q1 <= {q1[126:0], k1};
      q2 <= {q2[126:0], k2};
    end

    if (cmd.early) begin
      res_num <= '0; res_den <= '0; res_int <= '0; order <= '0;
      status  <= early_st;
    end else if (cmd.fin) begin
      res_num <= '0; res_den <= '0; res_int <= '0; order <= '0;
      status  <= rau_pkg::ST_OK;
      priority if (op_q == rau_pkg::OP_CMP) begin
        order <= ord_q;
      end else if (stat.is_int) begin
        if (fits(ineg, qq)) res_int <= ineg ? 64'(-qq[63:0]) : qq[63:0];
        else status <= rau_pkg::ST_OVF;
      end else begin
        if (fits(fneg, q1) && fits(1'b0, q2)) begin
          res_num <= fneg ? 64'(-q1[63:0]) : q1[63:0];
          res_den <= q2[62:0];
        end else begin
          status <= rau_pkg::ST_OVF;
        end
      end
    end
  end

  assign stat.early_hit = early_hit;
  assign stat.is_cmp    = (op_q == rau_pkg::OP_CMP);
  assign stat.is_int    = (op_q >= rau_pkg::OP_FLOOR) && (op_q <= rau_pkg::OP_ROUND);
  assign stat.gcd_done  = (gb == '0);

endmodule

// File: rtl/rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact gcd-reduced arithmetic on signed 64-bit fractions.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and the result
// appears for a single cycle with done high; the receiver cannot stall, so
// capture it then. Error checks finish before the multiply passes. Compare
// skips the gcd loop and divider, floor/ceil/round skip the gcd loop, and
// fractions also run the binary gcd loop (one shift or subtract per cycle
// on 128 bits). The 128-step restoring divider and gcd loop set the latency.
module rational_arithmetic_unit_top #(
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         op,
  input  logic signed [63:0] a_num,
  input  logic signed [63:0] a_den,
  input  logic signed [63:0] b_num,
  input  logic [62:0]        b_den,
  output logic               done,
  output logic signed [63:0] res_num,
  output logic [62:0]        res_den,
  output logic signed [63:0] res_int,
  output logic [1:0]         order,
  output logic [1:0]         status
);

  rau_pkg::cmd_t  cmd;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .stat    (stat),
    .op      (op),
    .a_num   (a_num),
    .a_den   (a_den),
    .b_num   (b_num),
    .b_den   (b_den),
    .res_num (res_num),
    .res_den (res_den),
    .res_int (res_int),
    .order   (order),
    .status  (status)
  );

endmodule
